/* rtl/core/cgi_pkg.sv */
// cgi_pkg: shared constants, types and helpers for the colour gradient interpolator
// used by every module under rtl/core; depends on nothing
`default_nettype none

package cgi_pkg;

  // fixed point format of positions
  localparam int unsigned FracBits = 16;
  localparam int unsigned PosW     = FracBits + 1;   // unsigned, 0..2.0 - lsb
  localparam int unsigned InW      = FracBits + 2;   // signed sample position
  localparam int unsigned RemW     = PosW + 1;       // divider partial remainder

  // gradient storage
  localparam int unsigned MaxMarks = 7;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned CntW     = 3;

  // colour channels, red first
  localparam int unsigned ChW   = 8;
  localparam int unsigned NumCh = 4;
  localparam int unsigned RgbaW = ChW * NumCh;
  localparam int unsigned ProdW = ChW + FracBits;

  // register port
  localparam int unsigned AddrW   = 6;
  localparam int unsigned AddrLsb = 3;
  localparam int unsigned DataW   = 64;

  localparam logic [PosW-1:0] PosOne = PosW'(1) << FracBits;

  // register indexes
  localparam logic [IdxW-1:0] RegMarkCount = IdxW'(0);
  localparam logic [IdxW-1:0] RegMarkFirst = IdxW'(1);

  // empty gradient colour: opaque black
  localparam logic [RgbaW-1:0] EmptyRgba = RgbaW'(8'hff);

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [RgbaW-1:0] rgba;
  } mark_t;

  // sideband that follows a word down the pipe
  typedef struct packed {
    logic            empty;  // no marks in use
    logic            flat;   // output the colour of mark idx as is
    logic [IdxW-1:0] idx;    // flat: mark to show, else lower mark of the span
  } tag_t;

  function automatic logic [ChW-1:0] mark_chan(input mark_t m, input int unsigned ch);
    mark_chan = m.rgba[ChW*(NumCh-1-ch) +: ChW];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cgi_select.sv */
// cgi_select: clamps the sample, finds the span of marks around it and forms
// the divider operands; two register stages, uses cgi_pkg
`default_nettype none

module cgi_select (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [cgi_pkg::InW-1:0]      sample_position_i,
  input  logic [cgi_pkg::CntW-1:0]            mark_count_i,
  input  cgi_pkg::mark_t [cgi_pkg::MaxMarks-1:0] marks_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [cgi_pkg::PosW-1:0]            num_o,
  output logic [cgi_pkg::PosW-1:0]            den_o,
  output cgi_pkg::tag_t                       tag_o
);
  import cgi_pkg::*;

  // stage a: clamp and compare
  logic                a_valid_q;
  logic [PosW-1:0]     a_t_q, a_t_d;
  logic [MaxMarks-1:0] a_lt_q, a_lt_d;
  logic                a_ready;

  // stage b: span select and operands
  logic            b_valid_q;
  logic [PosW-1:0] b_num_q, b_num_d;
  logic [PosW-1:0] b_den_q, b_den_d;
  tag_t            b_tag_q, b_tag_d;
  logic            b_ready;

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  always_comb begin
    logic [PosW-1:0] raw;
    raw = sample_position_i[InW-2:0];
    if (sample_position_i[InW-1]) begin
      a_t_d = '0;
    end else if (raw > PosOne) begin
      a_t_d = PosOne;
    end else begin
      a_t_d = raw;
    end
    for (int i = 0; i < MaxMarks; i++) begin
      a_lt_d[i] = (CntW'(i) < mark_count_i) && (a_t_d < marks_i[i].pos);
    end
  end

  always_comb begin
    logic [IdxW-1:0] up;
    logic            found;
    logic [IdxW-1:0] lo_idx;
    logic [IdxW-1:0] hi_idx;
    up    = IdxW'(mark_count_i);
    found = 1'b0;
    for (int i = 0; i < MaxMarks; i++) begin
      if (!found && a_lt_q[i]) begin
        up    = IdxW'(i);
        found = 1'b1;
      end
    end
    b_tag_d.empty = (mark_count_i == '0);
    b_tag_d.flat  = (up == '0) || (up == IdxW'(mark_count_i));
    if (up == '0) begin
      b_tag_d.idx = '0;
    end else if (b_tag_d.flat) begin
      b_tag_d.idx = IdxW'(mark_count_i) - IdxW'(1);
    end else begin
      b_tag_d.idx = up - IdxW'(1);
    end
    // operands only matter inside a span
    lo_idx  = b_tag_d.flat ? '0 : up - IdxW'(1);
    hi_idx  = b_tag_d.flat ? '0 : up;
    b_num_d = a_t_q - marks_i[lo_idx].pos;
    b_den_d = marks_i[hi_idx].pos - marks_i[lo_idx].pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_t_q  <= a_t_d;
      a_lt_q <= a_lt_d;
    end
    if (b_ready && a_valid_q) begin
      b_num_q <= b_num_d;
      b_den_q <= b_den_d;
      b_tag_q <= b_tag_d;
    end
  end

  assign valid_o = b_valid_q;
  assign num_o   = b_num_q;
  assign den_o   = b_den_q;
  assign tag_o   = b_tag_q;

endmodule

`default_nettype wire

/* rtl/core/cgi_divide.sv */
// cgi_divide: pipelined restoring divider, one quotient bit per stage,
// giving floor(num * 2^FracBits / den) for num < den; uses cgi_pkg
`default_nettype none

module cgi_divide (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [cgi_pkg::PosW-1:0]     num_i,
  input  logic [cgi_pkg::PosW-1:0]     den_i,
  input  cgi_pkg::tag_t                tag_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [cgi_pkg::FracBits-1:0] frac_o,
  output cgi_pkg::tag_t                tag_o
);
  import cgi_pkg::*;

  logic [FracBits-1:0]               valid_q;
  logic [FracBits:0]                 rdy;
  logic [FracBits-1:0][RemW-1:0]     rem_q;
  logic [FracBits-1:0][FracBits-1:0] quo_q;
  logic [FracBits-1:0][PosW-1:0]     den_q;
  tag_t [FracBits-1:0]               tag_q;

  assign rdy[FracBits] = ready_i;
  assign ready_o       = rdy[0];

  for (genvar k = 0; k < FracBits; k++) begin : g_stage
    logic                v_in;
    logic [RemW-1:0]     r_in;
    logic [FracBits-1:0] q_in;
    logic [PosW-1:0]     d_in;
    tag_t                t_in;
    logic [RemW-1:0]     shifted;
    logic                ge;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = {1'b0, num_i};
      assign q_in = '0;
      assign d_in = den_i;
      assign t_in = tag_i;
    end else begin : g_next
      assign v_in = valid_q[k-1];
      assign r_in = rem_q[k-1];
      assign q_in = quo_q[k-1];
      assign d_in = den_q[k-1];
      assign t_in = tag_q[k-1];
    end

    assign rdy[k]  = !valid_q[k] || rdy[k+1];
    assign shifted = {r_in[RemW-2:0], 1'b0};
    assign ge      = shifted >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        rem_q[k] <= ge ? shifted - {1'b0, d_in} : shifted;
        quo_q[k] <= {q_in[FracBits-2:0], ge};
        den_q[k] <= d_in;
        tag_q[k] <= t_in;
      end
    end
  end

  assign valid_o = valid_q[FracBits-1];
  assign frac_o  = quo_q[FracBits-1];
  assign tag_o   = tag_q[FracBits-1];

endmodule

`default_nettype wire

/* rtl/core/cgi_blend.sv */
// cgi_blend: per channel lerp between two mark colours with floor rounding,
// then the output register; multiply stage and add stage, uses cgi_pkg
`default_nettype none

module cgi_blend (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [cgi_pkg::FracBits-1:0]        frac_i,
  input  cgi_pkg::tag_t                       tag_i,
  input  cgi_pkg::mark_t [cgi_pkg::MaxMarks-1:0] marks_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [cgi_pkg::RgbaW-1:0]           rgba_o
);
  import cgi_pkg::*;

  // multiply stage
  logic                        m_valid_q;
  logic [NumCh-1:0][ChW-1:0]   m_lo_q, m_lo_d;
  logic [NumCh-1:0][ProdW-1:0] m_prod_q, m_prod_d;
  logic [NumCh-1:0]            m_neg_q, m_neg_d;
  tag_t                        m_tag_q;
  logic                        m_ready;

  // output register
  logic             f_valid_q;
  logic [RgbaW-1:0] f_rgba_q, f_rgba_d;
  logic             f_ready;

  assign f_ready = !f_valid_q || ready_i;
  assign m_ready = !m_valid_q || f_ready;
  assign ready_o = m_ready;

  always_comb begin
    logic [IdxW-1:0] hi_idx;
    logic [ChW-1:0]  lo_c;
    logic [ChW-1:0]  hi_c;
    logic [ChW-1:0]  mag;
    hi_idx = tag_i.flat ? tag_i.idx : tag_i.idx + IdxW'(1);
    for (int c = 0; c < NumCh; c++) begin
      lo_c        = mark_chan(marks_i[tag_i.idx], c);
      hi_c        = mark_chan(marks_i[hi_idx], c);
      m_neg_d[c]  = hi_c < lo_c;
      mag         = m_neg_d[c] ? lo_c - hi_c : hi_c - lo_c;
      m_lo_d[c]   = lo_c;
      m_prod_d[c] = ProdW'(mag) * ProdW'(frac_i);
    end
  end

  always_comb begin
    logic [ProdW:0]   bump;
    logic [ChW-1:0]   step;
    logic [ChW-1:0]   ch;
    for (int c = 0; c < NumCh; c++) begin
      // a falling channel rounds its step up so that the result floors
      bump = {1'b0, m_prod_q[c]} + (m_neg_q[c] ? (ProdW+1)'({FracBits{1'b1}}) : '0);
      step = ChW'(bump >> FracBits);
      if (m_tag_q.flat) begin
        ch = m_lo_q[c];
      end else if (m_neg_q[c]) begin
        ch = m_lo_q[c] - step;
      end else begin
        ch = m_lo_q[c] + step;
      end
      f_rgba_d[ChW*(NumCh-1-c) +: ChW] = ch;
    end
    if (m_tag_q.empty) begin
      f_rgba_d = EmptyRgba;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid_q <= valid_i;
      end
      if (f_ready) begin
        f_valid_q <= m_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_ready && valid_i) begin
      m_lo_q   <= m_lo_d;
      m_prod_q <= m_prod_d;
      m_neg_q  <= m_neg_d;
      m_tag_q  <= tag_i;
    end
    if (f_ready && m_valid_q) begin
      f_rgba_q <= f_rgba_d;
    end
  end

  assign valid_o = f_valid_q;
  assign rgba_o  = f_rgba_q;

endmodule

`default_nettype wire

/* rtl/core/color_gradient_interpolator.sv */
// color_gradient_interpolator: top level with the register port and the
// select, divide and blend pipeline; uses cgi_pkg, cgi_select, cgi_divide, cgi_blend
`default_nettype none

// Piecewise linear RGBA8 gradient lookup. Up to seven marks, each an unsigned
// Q1.16 position and an RGBA8 colour, sit in registers with the number of
// marks in use; marks are expected in position order. Each input word is a
// signed Q1.16 sample position, clamped to 0..1.0, and gives one colour word:
// below the first mark the first colour, at or above the last mark the last
// colour, in between a per channel linear blend rounded down, and opaque black
// when no mark is in use. The block is fully pipelined and takes one word per
// clock while in_ready_o is high; it has twenty register stages: the two
// select stages, sixteen divider stages (one fraction bit each) and the
// multiply and output stages. Any stage that holds no word keeps accepting
// while the output waits, and back pressure only stops the pipe once it is
// full. Registers sit at byte address 8 * index (count first, then marks 0 to
// 6, 64 bit data) and must only be written while no word is in flight.

module color_gradient_interpolator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cgi_pkg::AddrW-1:0]         paddr,
  input  logic [cgi_pkg::DataW-1:0]         pwdata,
  output logic [cgi_pkg::DataW-1:0]         prdata,
  output logic                              pready,
  // sample words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [cgi_pkg::InW-1:0]    sample_position_i,
  // colour words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cgi_pkg::ChW-1:0]           red_o,
  output logic [cgi_pkg::ChW-1:0]           green_o,
  output logic [cgi_pkg::ChW-1:0]           blue_o,
  output logic [cgi_pkg::ChW-1:0]           alpha_o
);
  import cgi_pkg::*;

  // configuration registers
  logic [CntW-1:0]         mark_count_q;
  mark_t [MaxMarks-1:0]    marks_q;
  logic [IdxW-1:0]         reg_idx;
  logic [IdxW-1:0]         mark_idx;
  logic                    wr_en;

  // pipe links
  logic                sel_valid, sel_ready;
  logic [PosW-1:0]     sel_num, sel_den;
  tag_t                sel_tag;
  logic                div_valid, div_ready;
  logic [FracBits-1:0] div_frac;
  tag_t                div_tag;
  logic [RgbaW-1:0]    rgba;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[AddrLsb +: IdxW];
  assign mark_idx = reg_idx - RegMarkFirst;
  assign wr_en    = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_count_q <= '0;
      marks_q      <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        RegMarkCount: begin
          mark_count_q <= pwdata[CntW-1:0];
        end
        default: begin
          // every other index is one of the marks
          marks_q[mark_idx] <= pwdata[$bits(mark_t)-1:0];
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegMarkCount: begin
        prdata = DataW'(mark_count_q);
      end
      default: begin
        prdata = DataW'(marks_q[mark_idx]);
      end
    endcase
  end

  // clamp, span search and divider operands
  cgi_select u_select (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (in_valid_i),
    .ready_o           (in_ready_o),
    .sample_position_i (sample_position_i),
    .mark_count_i      (mark_count_q),
    .marks_i           (marks_q),
    .valid_o           (sel_valid),
    .ready_i           (sel_ready),
    .num_o             (sel_num),
    .den_o             (sel_den),
    .tag_o             (sel_tag)
  );

  // blend fraction within the span
  cgi_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sel_valid),
    .ready_o (sel_ready),
    .num_i   (sel_num),
    .den_i   (sel_den),
    .tag_i   (sel_tag),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .frac_o  (div_frac),
    .tag_o   (div_tag)
  );

  // channel lerp and output register
  cgi_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .ready_o (div_ready),
    .frac_i  (div_frac),
    .tag_i   (div_tag),
    .marks_i (marks_q),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rgba_o  (rgba)
  );

  assign red_o   = rgba[ChW*3 +: ChW];
  assign green_o = rgba[ChW*2 +: ChW];
  assign blue_o  = rgba[ChW*1 +: ChW];
  assign alpha_o = rgba[ChW*0 +: ChW];

endmodule

`default_nettype wire
